### hdl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP cache with aging
// Command and status codes, table geometry, channel payloads, table entry.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);

  // Command codes
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_LEARN  = 3'd1;
  localparam logic [2:0] CMD_ADD    = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Reset value of the TTL register
  localparam logic [15:0] TTL_RESET = 16'd300;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [47:0] found_mac;
    logic        found_static;
    logic [4:0]  removed_count;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

endpackage

### hdl/arp_cache_with_aging.sv
// Sequence: a transfer in starts the scan; S_LAST compares the last entry;
//   learn and add then write back in S_WRITE; S_DONE presents the result.
// Throughput: one command at a time, taken only in S_IDLE once the prior result is
//   registered; the scan reads the entry RAM through its single read port, one entry per cycle.
// Reset: valid and static bits clear at once, seconds counter zero, TTL 300;
//   entry RAM contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// arp_cache_with_aging: IPv4-to-MAC table with TTL aging
// A small sequencer scans the entry RAM, one shared compare path per cycle,
// then writes back for learn and add and presents one result per command.
// ----------------------------------------------------------------------------
module arp_cache_with_aging (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  arpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output arpc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LAST  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [2:0]                    cmd_r, cmd_nxt;
  logic [31:0]                   ip_r, ip_nxt;
  logic [47:0]                   mac_r, mac_nxt;
  logic [31:0]                   sec_r, sec_nxt;
  logic [15:0]                   ttl_r, ttl_nxt;
  logic [arpc_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [arpc_pkg::IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                          found_r, found_nxt;
  logic [arpc_pkg::IDX_W-1:0]    match_idx_r, match_idx_nxt;
  logic                          free_found_r, free_found_nxt;
  logic [arpc_pkg::IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [47:0]                   fmac_r, fmac_nxt;
  logic                          fstat_r, fstat_nxt;
  logic [4:0]                    removed_r, removed_nxt;
  logic [arpc_pkg::ENTRIES-1:0]  valid_r, valid_nxt;
  logic [arpc_pkg::ENTRIES-1:0]  static_r, static_nxt;
  arpc_pkg::out_item_t           out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          in_xfer;
  logic                          ram_we;
  logic [arpc_pkg::IDX_W-1:0]    ram_waddr;
  arpc_pkg::entry_t              ram_wdata;
  arpc_pkg::entry_t              ram_rdata;

  logic                          ent_v;
  logic                          ent_st;
  logic                          ip_eq;
  logic [31:0]                   age;
  logic                          expired;
  logic                          is_ins;
  logic                          out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_ins    = (cmd_r == arpc_pkg::CMD_LEARN) || (cmd_r == arpc_pkg::CMD_ADD);

  // Entry storage, scanned by the issue counter
  arpc_ram #(
    .WIDTH (arpc_pkg::ENT_W),
    .DEPTH (arpc_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // Shared compare path on the entry returned by the RAM
  always_comb begin
    ent_v   = valid_r[rd_idx_r];
    ent_st  = static_r[rd_idx_r];
    ip_eq   = ent_v && (ram_rdata.ip == ip_r);
    age     = sec_r - ram_rdata.stamp;
    expired = ent_v && !ent_st && (age > {16'd0, ttl_r});
  end

  // Sequencer and per-entry actions
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    ip_nxt         = ip_r;
    mac_nxt        = mac_r;
    sec_nxt        = sec_r;
    ttl_nxt        = ttl_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = cnt_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    fmac_nxt       = fmac_r;
    fstat_nxt      = fstat_r;
    removed_nxt    = removed_r;
    valid_nxt      = valid_r;
    static_nxt     = static_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_waddr      = match_idx_r;
    ram_wdata      = '{ip: ip_r, mac: mac_r, stamp: sec_r};

    if (cfg_we) begin
      ttl_nxt = cfg_wdata;
    end

    // Process the entry read in the previous cycle
    if (rd_vld_r) begin
      case (cmd_r) inside
        arpc_pkg::CMD_LOOKUP: begin
          if (ip_eq && !found_r) begin
            found_nxt = 1'b1;
            fmac_nxt  = ram_rdata.mac;
            fstat_nxt = ent_st;
          end
        end
        arpc_pkg::CMD_LEARN, arpc_pkg::CMD_ADD: begin
          if (ip_eq && !found_r) begin
            found_nxt     = 1'b1;
            match_idx_nxt = rd_idx_r;
          end
          if (!ent_v && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rd_idx_r;
          end
        end
        arpc_pkg::CMD_DELETE: begin
          if (ip_eq) begin
            found_nxt            = 1'b1;
            valid_nxt[rd_idx_r]  = 1'b0;
            static_nxt[rd_idx_r] = 1'b0;
            removed_nxt          = removed_r + 5'd1;
          end
        end
        arpc_pkg::CMD_TICK: begin
          if (expired) begin
            valid_nxt[rd_idx_r] = 1'b0;
            removed_nxt         = removed_r + 5'd1;
          end
        end
        arpc_pkg::CMD_CLEAR: begin
          if (ent_v) begin
            removed_nxt = removed_r + 5'd1;
          end
          valid_nxt[rd_idx_r]  = 1'b0;
          static_nxt[rd_idx_r] = 1'b0;
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = in_data.command;
          ip_nxt         = in_data.ip_addr;
          mac_nxt        = in_data.mac_addr;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          fmac_nxt       = '0;
          fstat_nxt      = 1'b0;
          removed_nxt    = '0;
          if (in_data.command == arpc_pkg::CMD_TICK) begin
            sec_nxt = sec_r + 32'd1;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle
        rd_vld_nxt = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = is_ins ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        // Overwrite the matched entry, else fill the lowest free slot
        if (found_r) begin
          ram_we                  = 1'b1;
          ram_waddr               = match_idx_r;
          static_nxt[match_idx_r] = (cmd_r == arpc_pkg::CMD_ADD);
        end else if (free_found_r) begin
          ram_we                 = 1'b1;
          ram_waddr              = free_idx_r;
          valid_nxt[free_idx_r]  = 1'b1;
          static_nxt[free_idx_r] = (cmd_r == arpc_pkg::CMD_ADD);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_nxt = '0;
          case (cmd_r) inside
            arpc_pkg::CMD_LOOKUP: begin
              out_nxt.status       = found_r ? arpc_pkg::ST_OK : arpc_pkg::ST_NOTFOUND;
              out_nxt.hit          = found_r;
              out_nxt.found_mac    = fmac_r;
              out_nxt.found_static = fstat_r;
            end
            arpc_pkg::CMD_LEARN, arpc_pkg::CMD_ADD: begin
              out_nxt.status = (!found_r && !free_found_r) ? arpc_pkg::ST_FULL
                                                           : arpc_pkg::ST_OK;
              out_nxt.hit    = found_r;
            end
            arpc_pkg::CMD_DELETE: begin
              out_nxt.status        = found_r ? arpc_pkg::ST_OK : arpc_pkg::ST_NOTFOUND;
              out_nxt.hit           = found_r;
              out_nxt.removed_count = removed_r;
            end
            arpc_pkg::CMD_TICK, arpc_pkg::CMD_CLEAR: begin
              out_nxt.removed_count = removed_r;
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      static_r    <= '0;
      sec_r       <= '0;
      ttl_r       <= arpc_pkg::TTL_RESET;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      static_r    <= static_nxt;
      sec_r       <= sec_nxt;
      ttl_r       <= ttl_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ip_r         <= ip_nxt;
    mac_r        <= mac_nxt;
    cnt_r        <= cnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    found_r      <= found_nxt;
    match_idx_r  <= match_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    fmac_r       <= fmac_nxt;
    fstat_r      <= fstat_nxt;
    removed_r    <= removed_nxt;
    out_r        <= out_nxt;
  end

  // A transfer in starts the scan at entry zero
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("scan did not start at entry zero");

  // The last entry is always being compared when the scan ends
  a_last_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) |-> rd_vld_r)
    else $error("scan ended without a pending read");

  // Only learn and add reach write-back
  a_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> is_ins)
    else $error("write-back for a non-insert command");

  // A finished command with a free output register presents its result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not presented");

endmodule

### hdl/arpc_ram.sv
// ----------------------------------------------------------------------------
// arpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for arp_cache_with_aging
// Drives a short directed command list, then random command mixes under
// several TTL settings. Each accepted command runs through a behavioral copy
// of the table and the result is compared field by field as it comes out.
// ----------------------------------------------------------------------------
module testbench;

  // Command codes the block ignores
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  localparam int POOL_SIZE  = 24;
  localparam int PHASES     = 8;
  localparam int SETTLE_CYC = arpc_pkg::ENTRIES + 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  arpc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  arpc_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  // Shadow copy of the ARP table
  logic        arp_valid  [arpc_pkg::ENTRIES];
  logic        arp_static [arpc_pkg::ENTRIES];
  logic [31:0] arp_ip     [arpc_pkg::ENTRIES];
  logic [47:0] arp_mac    [arpc_pkg::ENTRIES];
  logic [31:0] arp_stamp  [arpc_pkg::ENTRIES];
  logic [31:0] arp_seconds;
  logic [15:0] arp_ttl;

  arpc_pkg::out_item_t pending_results[$];
  logic [31:0]         ip_pool[POOL_SIZE];
  int                  fail_count;
  bit                  idle_on;

  typedef struct {
    arpc_pkg::in_item_t  item;
    bit                  typed;
    arpc_pkg::out_item_t want;
  } probe_row_t;

  probe_row_t probe_rows[$];

  arp_cache_with_aging dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("arp_cache_with_aging regression: fail");
    $finish;
  end

  function automatic int find_ip(input logic [31:0] ip);
    int i;
    for (i = 0; i < arpc_pkg::ENTRIES; i++) begin
      if (arp_valid[i] && arp_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the result it gives
  function automatic arpc_pkg::out_item_t arp_predict(input arpc_pkg::in_item_t it);
    arpc_pkg::out_item_t r;
    int                  slot;
    int                  i;
    int                  gone;
    logic [31:0]         age;
    r    = '0;
    gone = 0;
    case (it.command) inside
      arpc_pkg::CMD_LOOKUP: begin
        slot = find_ip(it.ip_addr);
        if (slot >= 0) begin
          r.hit          = 1'b1;
          r.found_mac    = arp_mac[slot];
          r.found_static = arp_static[slot];
        end else begin
          r.status = arpc_pkg::ST_NOTFOUND;
        end
      end
      arpc_pkg::CMD_LEARN, arpc_pkg::CMD_ADD: begin
        slot = find_ip(it.ip_addr);
        if (slot >= 0) begin
          r.hit = 1'b1;
        end else begin
          for (i = arpc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!arp_valid[i]) slot = i;
          end
        end
        if (slot < 0) begin
          r.status = arpc_pkg::ST_FULL;
        end else begin
          arp_valid[slot]  = 1'b1;
          arp_ip[slot]     = it.ip_addr;
          arp_mac[slot]    = it.mac_addr;
          arp_static[slot] = (it.command == arpc_pkg::CMD_ADD);
          arp_stamp[slot]  = arp_seconds;
        end
      end
      arpc_pkg::CMD_DELETE: begin
        for (i = 0; i < arpc_pkg::ENTRIES; i++) begin
          if (arp_valid[i] && arp_ip[i] == it.ip_addr) begin
            arp_valid[i]  = 1'b0;
            arp_static[i] = 1'b0;
            gone++;
          end
        end
        if (gone > 0) r.hit = 1'b1;
        else r.status = arpc_pkg::ST_NOTFOUND;
      end
      arpc_pkg::CMD_TICK: begin
        arp_seconds = arp_seconds + 32'd1;
        for (i = 0; i < arpc_pkg::ENTRIES; i++) begin
          age = arp_seconds - arp_stamp[i];
          if (arp_valid[i] && !arp_static[i] && age > {16'h0, arp_ttl}) begin
            arp_valid[i] = 1'b0;
            gone++;
          end
        end
      end
      arpc_pkg::CMD_CLEAR: begin
        for (i = 0; i < arpc_pkg::ENTRIES; i++) begin
          if (arp_valid[i]) gone++;
          arp_valid[i]  = 1'b0;
          arp_static[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.removed_count = gone[4:0];
    return r;
  endfunction

  // Draw one random command; fill-heavy mixes insert more and clear less
  function automatic arpc_pkg::in_item_t random_cmd(input bit fill);
    arpc_pkg::in_item_t it;
    int                 pick;
    int                 t_lk, t_ln, t_ad, t_dl, t_tk, t_cl;
    logic [31:0]        lo, hi;
    if (fill) begin
      t_lk = 25; t_ln = 60; t_ad = 75; t_dl = 80; t_tk = 95; t_cl = 96;
    end else begin
      t_lk = 30; t_ln = 55; t_ad = 65; t_dl = 77; t_tk = 94; t_cl = 97;
    end
    pick = $urandom_range(0, 99);
    if (pick < t_lk)      it.command = arpc_pkg::CMD_LOOKUP;
    else if (pick < t_ln) it.command = arpc_pkg::CMD_LEARN;
    else if (pick < t_ad) it.command = arpc_pkg::CMD_ADD;
    else if (pick < t_dl) it.command = arpc_pkg::CMD_DELETE;
    else if (pick < t_tk) it.command = arpc_pkg::CMD_TICK;
    else if (pick < t_cl) it.command = arpc_pkg::CMD_CLEAR;
    else it.command = $urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7;
    if ($urandom_range(0, 9) != 0) it.ip_addr = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    else it.ip_addr = $urandom();
    lo = $urandom();
    hi = $urandom();
    case ($urandom_range(0, 19))
      0:       it.mac_addr = '0;
      1:       it.mac_addr = '1;
      default: it.mac_addr = {hi[15:0], lo};
    endcase
    return it;
  endfunction

  task automatic add_probe(input logic [2:0] cmd, input logic [31:0] ip,
                           input logic [47:0] mac, input bit typed,
                           input arpc_pkg::out_item_t want);
    probe_row_t row;
    row.item.command  = cmd;
    row.item.ip_addr  = ip;
    row.item.mac_addr = mac;
    row.typed         = typed;
    row.want          = want;
    probe_rows.push_back(row);
  endtask

  // Drop valid for a random burst now and then
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Offer one command and hold it until the transfer happens
  task automatic send_cmd(input arpc_pkg::in_item_t it, input bit typed,
                          input arpc_pkg::out_item_t want);
    arpc_pkg::out_item_t predicted;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = arp_predict(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Stop sending and wait until every result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [15:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    arp_ttl = value;
    cfg_we  <= 1'b0;
  endtask

  // Result side: check each transfer, stall in random bursts plus one long hold
  initial begin : result_side
    int                  stall_left;
    int                  seen;
    bit                  long_hold_done;
    arpc_pkg::out_item_t want;
    arpc_pkg::out_item_t got;
    stall_left     = 0;
    seen           = 0;
    long_hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = out_data;
        seen++;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status %0d hit %0d mac %h static %0d removed %0d",
                     got.status, got.hit, got.found_mac, got.found_static,
                     got.removed_count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.hit !== want.hit ||
              got.found_mac !== want.found_mac ||
              got.found_static !== want.found_static ||
              got.removed_count !== want.removed_count) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch:", seen);
              $display("  expected status %0d hit %0d mac %h static %0d removed %0d",
                       want.status, want.hit, want.found_mac, want.found_static,
                       want.removed_count);
              $display("  actual   status %0d hit %0d mac %h static %0d removed %0d",
                       got.status, got.hit, got.found_mac, got.found_static,
                       got.removed_count);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!long_hold_done && seen >= 60) begin
        stall_left     = 400;
        long_hold_done = 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Command side: reset, directed list, then random phases
  initial begin : stimulus
    int                 p;
    int                 i;
    int                 done;
    int                 n;
    arpc_pkg::in_item_t item;
    logic [15:0]        phase_ttl  [PHASES];
    int                 phase_len  [PHASES];
    bit                 phase_fill [PHASES];

    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    fail_count = 0;
    idle_on    = 1'b1;

    // Reset state of the shadow table
    for (i = 0; i < arpc_pkg::ENTRIES; i++) begin
      arp_valid[i]  = 1'b0;
      arp_static[i] = 1'b0;
      arp_ip[i]     = '0;
      arp_mac[i]    = '0;
      arp_stamp[i]  = '0;
    end
    arp_seconds = '0;
    arp_ttl     = arpc_pkg::TTL_RESET;

    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom();

    phase_ttl[0] = 16'd0;                        phase_len[0] = 180; phase_fill[0] = 0;
    phase_ttl[1] = 16'hFFFF;                     phase_len[1] = 220; phase_fill[1] = 1;
    phase_ttl[2] = 16'd1;                        phase_len[2] = 180; phase_fill[2] = 0;
    phase_ttl[3] = 16'd3;                        phase_len[3] = 180; phase_fill[3] = 1;
    phase_ttl[4] = 16'($urandom_range(0, 10));   phase_len[4] = 180; phase_fill[4] = 0;
    phase_ttl[5] = 16'($urandom_range(0, 65535)); phase_len[5] = 180; phase_fill[5] = 1;
    phase_ttl[6] = 16'd2;                        phase_len[6] = 200; phase_fill[6] = 0;
    phase_ttl[7] = 16'd5;                        phase_len[7] = 230; phase_fill[7] = 0;

    // Directed commands at the reset TTL
    add_probe(arpc_pkg::CMD_LOOKUP, 32'h0A00_0001, 48'h0, 1,
              {arpc_pkg::ST_NOTFOUND, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_DELETE, 32'hFFFF_FFFF, 48'h0, 1,
              {arpc_pkg::ST_NOTFOUND, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_TICK, 32'h0, 48'h0, 1,
              {arpc_pkg::ST_OK, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_CLEAR, 32'h0, 48'h0, 1,
              {arpc_pkg::ST_OK, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_LEARN, 32'h0, 48'h0, 1,
              {arpc_pkg::ST_OK, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1,
              {arpc_pkg::ST_OK, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1,
              {arpc_pkg::ST_OK, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 5'd0});
    add_probe(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 1,
              {arpc_pkg::ST_OK, 1'b1, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_LEARN, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 0, '0);
    add_probe(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 0, '0);
    add_probe(arpc_pkg::CMD_ADD, 32'h0, 48'hA5A5_A5A5_A5A5, 0, '0);
    add_probe(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 0, '0);
    add_probe(CMD_UNUSED6, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, '0);
    add_probe(CMD_UNUSED7, 32'h0, 48'h0, 1, '0);
    add_probe(arpc_pkg::CMD_TICK, 32'h0, 48'h0, 0, '0);
    add_probe(arpc_pkg::CMD_DELETE, 32'hFFFF_FFFF, 48'h0, 1,
              {arpc_pkg::ST_OK, 1'b1, 48'h0, 1'b0, 5'd1});
    add_probe(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1,
              {arpc_pkg::ST_NOTFOUND, 1'b0, 48'h0, 1'b0, 5'd0});
    add_probe(arpc_pkg::CMD_LEARN, 32'hC0A8_0001, 48'h0000_0000_0001, 0, '0);
    add_probe(arpc_pkg::CMD_LEARN, 32'h7FFF_FFFF, 48'h8000_0000_0000, 0, '0);
    add_probe(arpc_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 48'h0, 0, '0);
    add_probe(arpc_pkg::CMD_CLEAR, 32'h0, 48'h0, 0, '0);
    add_probe(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 1,
              {arpc_pkg::ST_NOTFOUND, 1'b0, 48'h0, 1'b0, 5'd0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[k]) begin
      maybe_gap();
      send_cmd(probe_rows[k].item, probe_rows[k].typed, probe_rows[k].want);
    end

    // Random phases, each with its own TTL written while the block is idle
    for (p = 0; p < PHASES; p++) begin
      drain();
      write_ttl(phase_ttl[p]);
      done = 0;
      n    = 0;
      while (done < phase_len[p]) begin
        if (n % 40 == 0) idle_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
        n++;
        item = random_cmd(phase_fill[p]);
        if (item.command <= arpc_pkg::CMD_CLEAR) done++;
        maybe_gap();
        send_cmd(item, 1'b0, '0);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("arp_cache_with_aging regression: pass");
    end else begin
      $display("arp_cache_with_aging regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arp_cache_with_aging.sv
bench/testbench.sv
